FILE: hw/rtl/vrfc_pkg.sv
// Package: widths, lane control type and output finishing for the vertical RGBA FIR convolver.
`default_nettype none
package vrfc_pkg;

  localparam int unsigned CoeffW    = 16;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned ProdW     = CoeffW + ChanW;
  localparam int unsigned AccW      = 32;
  localparam int unsigned ShiftBits = 14;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  typedef struct packed {
    logic load;    // capture coefficient and pixel byte into the product register
    logic adv;     // product register moves into the accumulator
    logic acc_en;  // product is added on this advance
    logic clr;     // last tap: accumulator clears after the result is taken
  } lane_ctrl_t;

  // Arithmetic shift right, then clamp to 0..255.
  function automatic logic [ChanW-1:0] finish(input logic [AccW-1:0] sum);
    logic [AccW-1:0] shifted;
    logic [ChanW-1:0] res;
    shifted = AccW'($signed(sum) >>> ShiftBits);
    if (shifted[AccW-1]) begin
      res = '0;
    end else if (|shifted[AccW-2:ChanW]) begin
      res = ChanMax;
    end else begin
      res = shifted[ChanW-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/vrfc_mac_lane.sv
// One channel lane: registered coefficient times pixel product, 32-bit accumulator, finishing.
`default_nettype none
module vrfc_mac_lane (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire vrfc_pkg::lane_ctrl_t      ctrl_i,
  input  wire logic [vrfc_pkg::CoeffW-1:0] coeff_i,
  input  wire logic [vrfc_pkg::ChanW-1:0]  pix_i,
  output logic      [vrfc_pkg::ChanW-1:0]  res_o
);

  logic signed [vrfc_pkg::ProdW-1:0] prod_d, prod_q;
  logic [vrfc_pkg::AccW-1:0] acc_d, acc_q;
  logic [vrfc_pkg::AccW-1:0] sum;

  assign prod_d = vrfc_pkg::ProdW'($signed(coeff_i)) *
                  vrfc_pkg::ProdW'($signed({1'b0, pix_i}));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    sum = acc_q;
    if (ctrl_i.acc_en) begin
      sum = acc_q + vrfc_pkg::AccW'(prod_q);
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.adv) begin
      acc_d = ctrl_i.clr ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign res_o = vrfc_pkg::finish(sum);

endmodule
`default_nettype wire

FILE: hw/rtl/vertical_rgba_fir_convolver_core.sv
// Top level: vertical RGBA FIR convolver, one tap per cycle while no result is blocked, registered RGBA result.
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+--------------------------------------------
//  in       | s_axis_tvalid/tready/tdata/tlast | tdata: coeff, red, green, blue, alpha; tlast
//  out      | m_axis_tvalid/tready/tdata       | tdata: red, green, blue, alpha
//  cfg      | cfg_we_i/cfg_wdata_i             | has_alpha
//
// One tap per cycle unless a blocked result holds a last tap. Two stages: product register, then
// accumulate and finish into the output register; a result is loaded when its last tap leaves the product stage.
// Reset clears accumulators, valids and has_alpha.
// A blocked result only holds back a last tap in the product stage; other taps keep flowing.
`default_nettype none
module vertical_rgba_fir_convolver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // coeff[15:0], red, green, blue, alpha
  input  wire logic        s_axis_tlast,  // last_tap
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // red, green, blue, alpha
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i    // has_alpha
);

  localparam int unsigned NumChan = 4;
  localparam int unsigned ChanW   = vrfc_pkg::ChanW;

  logic has_alpha_q;
  logic p_vld_q, p_last_q;
  logic p_fire, out_free, in_fire;
  logic m_valid_d, m_valid_q;
  logic [31:0] m_data_q;
  logic [ChanW-1:0] res [NumChan];
  logic [ChanW-1:0] ao, mx;
  vrfc_pkg::lane_ctrl_t ctrl [NumChan];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign p_fire        = p_vld_q && (!p_last_q || out_free);
  assign s_axis_tready = !p_vld_q || p_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_alpha_q <= 1'b0;
    end else if (cfg_we_i) begin
      has_alpha_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
    end else if (s_axis_tready) begin
      p_vld_q  <= s_axis_tvalid;
      p_last_q <= s_axis_tlast;
    end
  end

  for (genvar i = 0; i < NumChan; i++) begin : g_lane
    always_comb begin
      ctrl[i].load   = in_fire;
      ctrl[i].adv    = p_fire;
      ctrl[i].acc_en = (i == NumChan - 1) ? has_alpha_q : 1'b1;
      ctrl[i].clr    = p_last_q;
    end

    vrfc_mac_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[i]),
      .coeff_i (s_axis_tdata[vrfc_pkg::CoeffW-1:0]),
      .pix_i   (s_axis_tdata[vrfc_pkg::CoeffW + i*ChanW +: ChanW]),
      .res_o   (res[i])
    );
  end

  always_comb begin
    mx = res[0];
    if (res[1] > mx) begin
      mx = res[1];
    end
    if (res[2] > mx) begin
      mx = res[2];
    end
    if (!has_alpha_q) begin
      ao = vrfc_pkg::ChanMax;
    end else if (res[3] < mx) begin
      ao = mx;
    end else begin
      ao = res[3];
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (p_fire && p_last_q) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_fire && p_last_q) begin
      m_data_q <= {ao, res[2], res[1], res[0]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_fire && p_last_q |=> m_axis_tvalid)
    else $error("last tap advanced without a result");

  a_alpha_covers_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:24] >= m_axis_tdata[7:0] &&
                      m_axis_tdata[31:24] >= m_axis_tdata[15:8] &&
                      m_axis_tdata[31:24] >= m_axis_tdata[23:16])
    else $error("output alpha below a color channel");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> p_vld_q && p_last_q && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for the vertical RGBA FIR convolver: queued tap driver, pixel predictor and checker.
module tb_top;

  typedef struct {
    logic [15:0] coeff;
    logic [7:0]  red, green, blue, alpha;
    logic        last;
  } tap_t;

  typedef struct {
    logic [7:0] red, green, blue, alpha;
  } pixel_t;

  typedef enum int unsigned {COL_SMOOTH, COL_RANDOM, COL_EXTREME} col_kind_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;

  tap_t        pending_taps[$];
  pixel_t      expected_pixels[$];
  logic        alpha_en = 1'b0;
  logic [31:0] sum_red = '0, sum_green = '0, sum_blue = '0, sum_alpha = '0;
  int unsigned src_gap_pct = 0, sink_stall_pct = 0;
  int unsigned n_taps = 0, n_pixels = 0, n_errors = 0;

  vertical_rgba_fir_convolver_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // shift the signed sum down and saturate to a byte
  function automatic logic [7:0] scale_to_byte(logic [31:0] sum);
    logic signed [31:0] scaled;
    scaled = $signed(sum) >>> vrfc_pkg::ShiftBits;
    if (scaled < 0) return 8'h00;
    if (scaled > 255) return 8'hFF;
    return scaled[7:0];
  endfunction

  function automatic void accumulate_tap(logic [15:0] coeff, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b, logic [7:0] a, logic last);
    logic [31:0] c32;
    logic [7:0]  top;
    pixel_t      px;
    c32       = {{16{coeff[15]}}, coeff};
    sum_red   = sum_red + c32 * {24'd0, r};
    sum_green = sum_green + c32 * {24'd0, g};
    sum_blue  = sum_blue + c32 * {24'd0, b};
    if (alpha_en) sum_alpha = sum_alpha + c32 * {24'd0, a};
    if (last) begin
      px.red   = scale_to_byte(sum_red);
      px.green = scale_to_byte(sum_green);
      px.blue  = scale_to_byte(sum_blue);
      if (alpha_en) begin
        px.alpha = scale_to_byte(sum_alpha);
        top = px.red;
        if (px.green > top) top = px.green;
        if (px.blue > top) top = px.blue;
        if (px.alpha < top) px.alpha = top;
      end else begin
        px.alpha = 8'hFF;
      end
      expected_pixels.push_back(px);
      sum_red   = '0;
      sum_green = '0;
      sum_blue  = '0;
      sum_alpha = '0;
    end
  endfunction

  function automatic void check_chan(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      n_errors++;
    end
  endfunction

  function automatic void push_tap(logic [15:0] coeff, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] b, logic [7:0] a, logic last);
    tap_t t;
    t.coeff = coeff;
    t.red   = r;
    t.green = g;
    t.blue  = b;
    t.alpha = a;
    t.last  = last;
    pending_taps.push_back(t);
  endfunction

  function automatic logic [7:0] pixel_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one column of len taps; close=0 leaves it open for the next phase
  function automatic int unsigned push_column(int unsigned len, col_kind_e kind, logic close);
    logic [15:0] c;
    for (int unsigned k = 0; k < len; k++) begin
      case (kind)
        COL_SMOOTH: begin
          c = 16'($urandom_range((len == 1) ? 32767 : 32768 / len));
          if ($urandom_range(3) == 0) c = -c;
        end
        COL_RANDOM: c = 16'($urandom);
        default: begin
          case ($urandom_range(3))
            0: c = 16'h7FFF;
            1: c = 16'h8000;
            2: c = 16'h0000;
            default: c = 16'hFFFF;
          endcase
        end
      endcase
      push_tap(c, pixel_byte(), pixel_byte(), pixel_byte(), pixel_byte(),
               close && (k == len - 1));
    end
    return len;
  endfunction

  // wait until every tap is in and every pixel is out, then let the pipeline drain
  task automatic settle();
    while (pending_taps.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_alpha_en(logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    alpha_en    <= v;
  endtask

  // driver: source side and sink backpressure
  always @(posedge clk_i) begin : drive
    tap_t nxt;
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_taps.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
        nxt = pending_taps.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nxt.alpha, nxt.blue, nxt.green, nxt.red, nxt.coeff};
        s_axis_tlast  <= nxt.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: check output transactions, predict from input transactions
  always @(posedge clk_i) begin : watch
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_chan("out_red", want.red, m_axis_tdata[7:0]);
        check_chan("out_green", want.green, m_axis_tdata[15:8]);
        check_chan("out_blue", want.blue, m_axis_tdata[23:16]);
        check_chan("out_alpha", want.alpha, m_axis_tdata[31:24]);
        n_pixels++;
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      accumulate_tap(s_axis_tdata[15:0], s_axis_tdata[23:16], s_axis_tdata[31:24],
                     s_axis_tdata[39:32], s_axis_tdata[47:40], s_axis_tlast);
      n_taps++;
    end
  end

  initial begin : stimulus
    int unsigned phase_taps;
    int unsigned len;
    int unsigned pick;
    col_kind_e   kind;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_alpha_en(1'b0);
    @(negedge clk_i);
    push_tap(16'h4000, 8'd255, 8'd0, 8'd128, 8'd77, 1'b1);
    push_tap(16'h7FFF, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    push_tap(16'h8000, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    push_tap(16'hFFFF, 8'd1, 8'd1, 8'd1, 8'd1, 1'b1);
    push_tap(16'h0000, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    push_tap(16'h1000, 8'd10, 8'd200, 8'd30, 8'd40, 1'b0);
    push_tap(16'h2000, 8'd20, 8'd100, 8'd60, 8'd80, 1'b0);
    push_tap(16'h1000, 8'd30, 8'd50, 8'd90, 8'd120, 1'b1);
    settle();
    write_alpha_en(1'b1);
    @(negedge clk_i);
    push_tap(16'h4000, 8'd10, 8'd20, 8'd30, 8'd200, 1'b1);
    push_tap(16'h4000, 8'd10, 8'd250, 8'd30, 8'd5, 1'b1);
    push_tap(16'hC000, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
    push_tap(16'h4000, 8'd0, 8'd0, 8'd0, 8'd100, 1'b1);
    push_tap(16'h7FFF, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
    // alpha switched off mid-column
    push_tap(16'h2000, 8'd100, 8'd100, 8'd100, 8'd200, 1'b0);
    push_tap(16'h2000, 8'd100, 8'd100, 8'd100, 8'd200, 1'b0);
    settle();
    write_alpha_en(1'b0);
    @(negedge clk_i);
    push_tap(16'h4000, 8'd50, 8'd60, 8'd70, 8'd80, 1'b1);
    // alpha switched on mid-column: only the second half counts
    push_tap(16'h2000, 8'd40, 8'd40, 8'd40, 8'd250, 1'b0);
    settle();
    write_alpha_en(1'b1);
    @(negedge clk_i);
    push_tap(16'h2000, 8'd40, 8'd40, 8'd40, 8'd100, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_alpha_en(ph == 0 || ph == 2);
      @(negedge clk_i);
      case (ph)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 46; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 46; end
        default: begin src_gap_pct = 33; sink_stall_pct = 33; end
      endcase
      phase_taps = 0;
      // long columns at full scale wrap the accumulators
      if (ph % 2 == 1) begin
        for (int k = 0; k < 270; k++)
          push_tap((ph == 1) ? 16'h7FFF : 16'h8000, 8'd255, 8'd255, 8'd255, 8'd255, k == 269);
        phase_taps += 270;
      end
      while (phase_taps < 460) begin
        len  = ($urandom_range(15) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
        pick = $urandom_range(99);
        kind = (pick < 70) ? COL_SMOOTH : (pick < 90) ? COL_RANDOM : COL_EXTREME;
        phase_taps += push_column(len, kind, 1'b1);
      end
      if (ph < 3) phase_taps += push_column(2, COL_SMOOTH, 1'b0);
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("%0d taps driven, %0d pixels checked", n_taps, n_pixels);
    $display("alpha on and off, mid-column register changes, accumulator wrap, four idle mixes");
    if (n_errors == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d pixels pending", expected_pixels.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
